// ----- hdl/hashed_lru_block_buffer_cache_unit_macros.svh -----
// ----------------------------------------------------------------------------
// hashed lru block buffer cache assertion macros
// shared assertion forms, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef HASHED_LRU_BLOCK_BUFFER_CACHE_UNIT_MACROS_SVH
`define HASHED_LRU_BLOCK_BUFFER_CACHE_UNIT_MACROS_SVH

// same-cycle implication
`define HLBC_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("hlbc assertion failed");

// next-cycle implication
`define HLBC_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("hlbc assertion failed");

`endif

// ----- hdl/hlbc_pkg.sv -----
// ----------------------------------------------------------------------------
// hlbc_pkg
// constants, types, command codes and link reset values for the cache
// ----------------------------------------------------------------------------
package hlbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int NUM_BUCKETS = 13;
  localparam int NODE_COUNT  = NUM_BUFFERS + NUM_BUCKETS;
  localparam int BUF_W       = $clog2(NUM_BUFFERS);
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SB_W        = BKT_W + 1;
  localparam int STEP_W      = BUF_W + 1;
  localparam int HASH_W      = BKT_W + 4;
  localparam int IDX_W       = 5;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 8;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 2;
  localparam int OP_W        = 5;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [BUF_W-1:0]  buf_t;
  typedef logic [BKT_W-1:0]  bkt_t;
  typedef logic [OP_W-1:0]   op_t;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REL   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PIN   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNPIN = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER  = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVER   = 2'd3;

  localparam op_t OP_NOP           = 5'd0;
  localparam op_t OP_LOAD          = 5'd1;
  localparam op_t OP_HASH_STEP     = 5'd2;
  localparam op_t OP_HASH_TAG      = 5'd3;
  localparam op_t OP_HIT_RD        = 5'd4;
  localparam op_t OP_HIT_CHK       = 5'd5;
  localparam op_t OP_HIT_DONE      = 5'd6;
  localparam op_t OP_FREE_OWN_RD   = 5'd7;
  localparam op_t OP_FREE_STEAL_RD = 5'd8;
  localparam op_t OP_FREE_CHK      = 5'd9;
  localparam op_t OP_STEAL_INIT    = 5'd10;
  localparam op_t OP_STEAL_NEXT    = 5'd11;
  localparam op_t OP_SEL_IDX       = 5'd12;
  localparam op_t OP_RM_RD         = 5'd13;
  localparam op_t OP_RM_WR         = 5'd14;
  localparam op_t OP_PU_RD         = 5'd15;
  localparam op_t OP_PU_WR1        = 5'd16;
  localparam op_t OP_PU_WR2        = 5'd17;
  localparam op_t OP_CLAIM         = 5'd18;
  localparam op_t OP_FAIL          = 5'd19;
  localparam op_t OP_CNT           = 5'd20;
  localparam op_t OP_EMIT          = 5'd21;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic hash_last;
    logic srch_end;
    logic srch_match;
    logic sb_end;
    logic sb_skip;
    logic is_get;
    logic rel_zero;
    logic out_free;
  } sts_t;

  // reset chain: bucket zero holds NUM_BUFFERS-1 down to 0 from its head
  function automatic node_t fwd_reset(input node_t n);
    node_t r;
    if (n < node_t'(NUM_BUFFERS)) begin
      r = (n == '0) ? node_t'(NUM_BUFFERS) : n - node_t'(1);
    end else if (n == node_t'(NUM_BUFFERS)) begin
      r = node_t'(NUM_BUFFERS - 1);
    end else begin
      r = n;
    end
    return r;
  endfunction

  function automatic node_t bwd_reset(input node_t n);
    node_t r;
    if (n < node_t'(NUM_BUFFERS)) begin
      r = (n == node_t'(NUM_BUFFERS - 1)) ? node_t'(NUM_BUFFERS) : n + node_t'(1);
    end else if (n == node_t'(NUM_BUFFERS)) begin
      r = '0;
    end else begin
      r = n;
    end
    return r;
  endfunction

  // one nibble of the block number modulo the bucket count
  function automatic bkt_t hash_step(input bkt_t rem, input logic [3:0] nib);
    logic [HASH_W-1:0] v;
    v = {rem, nib};
    for (int k = 3; k >= 0; k--) begin
      if (v >= (HASH_W'(NUM_BUCKETS) << k)) begin
        v = v - (HASH_W'(NUM_BUCKETS) << k);
      end
    end
    return v[BKT_W-1:0];
  endfunction

endpackage

// ----- hdl/hlbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// hlbc_ctrl
// sequencer for get, release, pin and unpin transactions
// ----------------------------------------------------------------------------
module hlbc_ctrl
  import hlbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_HASH     = 5'd2;
  localparam logic [4:0] S_HIT_RD   = 5'd3;
  localparam logic [4:0] S_HIT_CHK  = 5'd4;
  localparam logic [4:0] S_HIT_DONE = 5'd5;
  localparam logic [4:0] S_FREE_OWN = 5'd6;
  localparam logic [4:0] S_FREE_CHK = 5'd7;
  localparam logic [4:0] S_ST_INIT  = 5'd8;
  localparam logic [4:0] S_ST_NEXT  = 5'd9;
  localparam logic [4:0] S_ST_CHK   = 5'd10;
  localparam logic [4:0] S_SEL      = 5'd11;
  localparam logic [4:0] S_RM_RD    = 5'd12;
  localparam logic [4:0] S_RM_WR    = 5'd13;
  localparam logic [4:0] S_PU_RD    = 5'd14;
  localparam logic [4:0] S_PU_WR1   = 5'd15;
  localparam logic [4:0] S_PU_WR2   = 5'd16;
  localparam logic [4:0] S_CLAIM    = 5'd17;
  localparam logic [4:0] S_FAIL     = 5'd18;
  localparam logic [4:0] S_CNT      = 5'd19;
  localparam logic [4:0] S_EMIT     = 5'd20;

  logic [4:0] state, state_next;
  logic       stealing, stealing_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    stealing_next = stealing;
    cmd.op        = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = sts.is_get ? S_HASH : S_CNT;
      end
      S_HASH: begin
        cmd.op = OP_HASH_STEP;
        if (sts.hash_last) begin
          state_next = sts.is_get ? S_HIT_RD : S_SEL;
        end
      end
      S_HIT_RD: begin
        cmd.op     = OP_HIT_RD;
        state_next = S_HIT_CHK;
      end
      S_HIT_CHK: begin
        cmd.op = OP_HIT_CHK;
        if (sts.srch_end) begin
          state_next = S_FREE_OWN;
        end else if (sts.srch_match) begin
          state_next = S_HIT_DONE;
        end
      end
      S_HIT_DONE: begin
        cmd.op     = OP_HIT_DONE;
        state_next = S_EMIT;
      end
      S_FREE_OWN: begin
        cmd.op        = OP_FREE_OWN_RD;
        stealing_next = 1'b0;
        state_next    = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.op = OP_FREE_CHK;
        if (sts.srch_end) begin
          state_next = stealing ? S_ST_NEXT : S_ST_INIT;
        end else if (sts.srch_match) begin
          state_next = stealing ? S_RM_RD : S_CLAIM;
        end
      end
      S_ST_INIT: begin
        cmd.op        = OP_STEAL_INIT;
        stealing_next = 1'b1;
        state_next    = S_ST_CHK;
      end
      S_ST_NEXT: begin
        cmd.op     = OP_STEAL_NEXT;
        state_next = S_ST_CHK;
      end
      S_ST_CHK: begin
        if (sts.sb_end) begin
          state_next = S_FAIL;
        end else if (sts.sb_skip) begin
          state_next = S_ST_NEXT;
        end else begin
          cmd.op     = OP_FREE_STEAL_RD;
          state_next = S_FREE_CHK;
        end
      end
      S_SEL: begin
        cmd.op     = OP_SEL_IDX;
        state_next = S_RM_RD;
      end
      S_RM_RD: begin
        cmd.op     = OP_RM_RD;
        state_next = S_RM_WR;
      end
      S_RM_WR: begin
        cmd.op     = OP_RM_WR;
        state_next = S_PU_RD;
      end
      S_PU_RD: begin
        cmd.op     = OP_PU_RD;
        state_next = S_PU_WR1;
      end
      S_PU_WR1: begin
        cmd.op     = OP_PU_WR1;
        state_next = S_PU_WR2;
      end
      S_PU_WR2: begin
        cmd.op     = OP_PU_WR2;
        state_next = sts.is_get ? S_CLAIM : S_EMIT;
      end
      S_CLAIM: begin
        cmd.op     = OP_CLAIM;
        state_next = S_EMIT;
      end
      S_FAIL: begin
        cmd.op     = OP_FAIL;
        state_next = S_EMIT;
      end
      S_CNT: begin
        cmd.op     = OP_CNT;
        state_next = sts.rel_zero ? S_HASH : S_EMIT;
        if (sts.rel_zero) begin
          state_next = S_HASH;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      stealing <= 1'b0;
    end else begin
      state    <= state_next;
      stealing <= stealing_next;
    end
  end

endmodule

// ----- hdl/hlbc_dpath.sv -----
// ----------------------------------------------------------------------------
// hlbc_dpath
// tag store, reference counts, bucket link memories, hash and result path
// ----------------------------------------------------------------------------
`include "hashed_lru_block_buffer_cache_unit_macros.svh"

module hlbc_dpath
  import hlbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [FUNC_W-1:0] func,
  input  logic [DATA_W-1:0] device,
  input  logic [DATA_W-1:0] block_number,
  input  logic [IDX_W-1:0]  buffer_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  granted_buffer,
  output logic              hit,
  output logic              needs_read,
  output logic [STAT_W-1:0] status
);

  // request
  logic [FUNC_W-1:0] r_func;
  logic [DATA_W-1:0] r_dev, r_blk;
  logic [IDX_W-1:0]  r_idx;

  // hash
  logic [DATA_W-1:0] hsrc;
  logic [2:0]        hcnt;
  bkt_t              hrem;

  // search
  logic [SB_W-1:0]   sb;
  node_t             srch_h, node, first;
  logic [STEP_W-1:0] steps;

  // buffer state
  logic [DATA_W-1:0] tdev [NUM_BUFFERS];
  logic [DATA_W-1:0] tblk [NUM_BUFFERS];
  logic [CNT_W-1:0]  rc   [NUM_BUFFERS];
  logic              cval [NUM_BUFFERS];

  // link memories
  node_t fmem [NODE_COUNT];
  node_t bmem [NODE_COUNT];
  logic  fvld [NODE_COUNT];
  logic  bvld [NODE_COUNT];
  node_t f_q, b_q, f_aq, b_aq;
  logic  f_vq, b_vq;
  node_t f_ra, b_ra, f_wa, b_wa, f_wd, b_wd;
  logic  f_we, b_we;
  node_t f_data, b_data;

  // result
  logic [IDX_W-1:0]  res_granted;
  logic              res_hit, res_need;
  logic [STAT_W-1:0] res_status;

  node_t head_own, head_sb, scur;
  buf_t  sbi, nbi, ibi;
  logic  idx_ok;

  assign f_data   = f_vq ? f_q : fwd_reset(f_aq);
  assign b_data   = b_vq ? b_q : bwd_reset(b_aq);
  assign head_own = node_t'(NUM_BUFFERS) + node_t'(hrem);
  assign head_sb  = node_t'(NUM_BUFFERS) + node_t'(sb);
  assign scur     = (cmd.op == OP_FREE_CHK) ? b_data : f_data;
  assign sbi      = scur[BUF_W-1:0];
  assign nbi      = node[BUF_W-1:0];
  assign ibi      = buf_t'(r_idx);
  assign idx_ok   = (32'(r_idx) < NUM_BUFFERS);

  always_comb begin
    sts.hash_last = (hcnt == 3'd7);
    sts.srch_end  = (scur == srch_h) || (scur >= node_t'(NUM_BUFFERS))
                    || (steps >= STEP_W'(NUM_BUFFERS));
    if (cmd.op == OP_FREE_CHK) begin
      sts.srch_match = (rc[sbi] == '0);
    end else begin
      sts.srch_match = (tdev[sbi] == r_dev) && (tblk[sbi] == r_blk);
    end
    sts.sb_end   = (sb >= SB_W'(NUM_BUCKETS));
    sts.sb_skip  = (sb == SB_W'(hrem));
    sts.is_get   = (r_func == FUNC_GET);
    sts.rel_zero = (r_func == FUNC_REL) && idx_ok && (rc[ibi] == CNT_W'(1));
    sts.out_free = !out_valid || !out_stall;
  end

  always_comb begin
    f_ra = head_own;
    b_ra = head_own;
    f_we = 1'b0;
    b_we = 1'b0;
    f_wa = node;
    b_wa = node;
    f_wd = f_data;
    b_wd = b_data;
    case (cmd.op)
      OP_HIT_CHK:       f_ra = f_data;
      OP_FREE_STEAL_RD: b_ra = head_sb;
      OP_FREE_CHK:      b_ra = b_data;
      OP_RM_RD: begin
        f_ra = node;
        b_ra = node;
      end
      OP_RM_WR: begin
        b_we = 1'b1;
        b_wa = f_data;
        b_wd = b_data;
        f_we = 1'b1;
        f_wa = b_data;
        f_wd = f_data;
      end
      OP_PU_WR1: begin
        f_we = 1'b1;
        f_wa = node;
        f_wd = f_data;
        b_we = 1'b1;
        b_wa = node;
        b_wd = head_own;
      end
      OP_PU_WR2: begin
        b_we = 1'b1;
        b_wa = first;
        b_wd = node;
        f_we = 1'b1;
        f_wa = head_own;
        f_wd = node;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_wa] <= f_wd;
    end
    if (b_we) begin
      bmem[b_wa] <= b_wd;
    end
    f_q  <= fmem[f_ra];
    b_q  <= bmem[b_ra];
    f_aq <= f_ra;
    b_aq <= b_ra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        fvld[i] <= 1'b0;
        bvld[i] <= 1'b0;
      end
      f_vq <= 1'b0;
      b_vq <= 1'b0;
    end else begin
      if (f_we) begin
        fvld[f_wa] <= 1'b1;
      end
      if (b_we) begin
        bvld[b_wa] <= 1'b1;
      end
      f_vq <= fvld[f_ra];
      b_vq <= bvld[b_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tdev[i] <= '0;
        tblk[i] <= '0;
        rc[i]   <= '0;
        cval[i] <= 1'b0;
      end
    end else begin
      case (cmd.op)
        OP_HIT_DONE: begin
          if (rc[nbi] != COUNT_MAX) begin
            rc[nbi] <= rc[nbi] + CNT_W'(1);
          end
          cval[nbi] <= 1'b1;
        end
        OP_CLAIM: begin
          tdev[nbi] <= r_dev;
          tblk[nbi] <= r_blk;
          rc[nbi]   <= CNT_W'(1);
          cval[nbi] <= 1'b1;
        end
        OP_CNT: begin
          if (idx_ok) begin
            if (r_func == FUNC_PIN) begin
              if (rc[ibi] != COUNT_MAX) begin
                rc[ibi] <= rc[ibi] + CNT_W'(1);
              end
            end else if (rc[ibi] != '0) begin
              rc[ibi] <= rc[ibi] - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        r_func <= func;
        r_dev  <= device;
        r_blk  <= block_number;
        r_idx  <= buffer_index;
        hsrc   <= block_number;
        hcnt   <= '0;
        hrem   <= '0;
      end
      OP_HASH_TAG: begin
        hsrc <= tblk[ibi];
        hcnt <= '0;
        hrem <= '0;
      end
      OP_HASH_STEP: begin
        hrem <= hash_step(hrem, hsrc[DATA_W-1 -: 4]);
        hsrc <= hsrc << 4;
        hcnt <= hcnt + 3'd1;
      end
      OP_HIT_RD, OP_FREE_OWN_RD: begin
        srch_h <= head_own;
        steps  <= '0;
      end
      OP_FREE_STEAL_RD: begin
        srch_h <= head_sb;
        steps  <= '0;
      end
      OP_HIT_CHK, OP_FREE_CHK: begin
        node  <= scur;
        steps <= steps + STEP_W'(1);
      end
      OP_STEAL_INIT: sb <= '0;
      OP_STEAL_NEXT: sb <= sb + SB_W'(1);
      OP_SEL_IDX:    node <= node_t'(ibi);
      OP_PU_WR1:     first <= f_data;
      OP_HIT_DONE: begin
        res_granted <= IDX_W'(nbi);
        res_hit     <= 1'b1;
        res_need    <= !cval[nbi];
        res_status  <= (rc[nbi] == COUNT_MAX) ? ST_OVER : ST_OK;
      end
      OP_CLAIM: begin
        res_granted <= IDX_W'(nbi);
        res_hit     <= 1'b0;
        res_need    <= 1'b1;
        res_status  <= ST_OK;
      end
      OP_FAIL: begin
        res_granted <= '0;
        res_hit     <= 1'b0;
        res_need    <= 1'b0;
        res_status  <= ST_NOFREE;
      end
      OP_CNT: begin
        res_granted <= r_idx;
        res_hit     <= 1'b0;
        res_need    <= 1'b0;
        res_status  <= ST_OK;
        if (idx_ok) begin
          if (r_func == FUNC_PIN) begin
            if (rc[ibi] == COUNT_MAX) begin
              res_status <= ST_OVER;
            end
          end else if (rc[ibi] == '0) begin
            res_status <= ST_UNDER;
          end
        end
        hsrc <= tblk[ibi];
        hcnt <= '0;
        hrem <= '0;
      end
      OP_EMIT: begin
        granted_buffer <= res_granted;
        hit            <= res_hit;
        needs_read     <= res_need;
        status         <= res_status;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `HLBC_ASSERT_IMP(a_emit_slot_free, cmd.op == OP_EMIT, !out_valid || !out_stall)
  `HLBC_ASSERT_NXT(a_emit_shows, cmd.op == OP_EMIT, out_valid)
  `HLBC_ASSERT_IMP(a_grant_is_buffer, cmd.op == OP_CLAIM || cmd.op == OP_HIT_DONE,
                   node < node_t'(NUM_BUFFERS))
  `HLBC_ASSERT_IMP(a_bucket_in_range, cmd.op == OP_HIT_RD || cmd.op == OP_PU_RD,
                   hrem < bkt_t'(NUM_BUCKETS))

endmodule

// ----- hdl/hashed_lru_block_buffer_cache_unit.sv -----
// ----------------------------------------------------------------------------
// hashed_lru_block_buffer_cache_unit
// tag manager for a hashed, recency ordered pool of disk block buffers
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with func, device, block_number and
// buffer_index; one transaction is taken whenever the unit is not busy.
// output channel: out_valid/out_stall with granted_buffer, hit, needs_read
// and status; one result per input transaction, held in an output register
// so a new input is taken while the last result still waits.
// sequence: pin, unpin and release update the count and emit; a release
// that frees the buffer also hashes its tag and relinks it at the head of
// its bucket. a get walks its bucket for a hit; a miss then walks the own
// bucket backward for a free buffer, and failing that steals by probing the
// other buckets in turn, walking each for a free buffer and relinking the
// one found into the own bucket. the walks step one link per cycle through
// the forward and backward link memories; the bucket number comes from a
// nibble-serial modulo over the eight nibbles of the block number.
// reset: all buffers sit in bucket zero with zero tags, counts and valids;
// link memories read their reset chain through per-entry valid bits, so no
// clearing pass is needed.
// stall: a held result keeps its payload; the next result waits for it.
// ----------------------------------------------------------------------------
module hashed_lru_block_buffer_cache_unit
  import hlbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [DATA_W-1:0] device,
  input  logic [DATA_W-1:0] block_number,
  input  logic [IDX_W-1:0]  buffer_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  granted_buffer,
  output logic              hit,
  output logic              needs_read,
  output logic [STAT_W-1:0] status
);

  cmd_t cmd;
  sts_t sts;

  hlbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlbc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .func           (func),
    .device         (device),
    .block_number   (block_number),
    .buffer_index   (buffer_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_buffer (granted_buffer),
    .hit            (hit),
    .needs_read     (needs_read),
    .status         (status)
  );

endmodule
